>>> rtl/core/bmp_pkg.sv
// Package for the BMP stream encoder: types, codes and header constants.
`timescale 1ns / 1ps

package bmp_pkg;

  // Largest width and height magnitude that the encoder accepts before saturating.
  localparam int MAX_DIM = 4096;

  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 14;
  localparam int ARR_W    = 28;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [5:0]  HDR_LAST_POS   = 6'd53;
  localparam logic [7:0]  HDR_MAGIC_B    = 8'h42;
  localparam logic [7:0]  HDR_MAGIC_M    = 8'h4D;
  localparam logic [31:0] HDR_OFFSET     = 32'd54;
  localparam logic [31:0] HDR_RESERVED   = 32'h656E_6552;
  localparam logic [31:0] HDR_INFO_SIZE  = 32'd40;
  localparam logic [31:0] HDR_PLANES_BPP = 32'h0018_0001;
  localparam logic [31:0] HDR_DPM        = 32'd2835;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_PIXEL,
    CMD_ERROR
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HEADER,
    BK_PIXEL,
    BK_ERROR
  } bk_state_t;

  // One queued job for the byte sequencer.
  typedef struct packed {
    cmd_kind_t           kind;
    logic [WIDTH_W-1:0]  hdr_width;
    logic [HEIGHT_W-1:0] hdr_height;
    logic [ARR_W-1:0]    hdr_arr;
    logic                hdr_empty;
    logic [7:0]          px_blue;
    logic [7:0]          px_green;
    logic [7:0]          px_red;
    logic [1:0]          pad;
    logic                file_end;
  } cmd_t;

endpackage

>>> rtl/core/bmp_ifs.sv
// Valid/ready channel interfaces for the BMP stream encoder.
`timescale 1ns / 1ps

interface bmp_in_if;
  import bmp_pkg::*;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] pixel_word;

  modport source (output valid, output op, output pixel_word, input ready);
  modport sink   (input valid, input op, input pixel_word, output ready);
endinterface

interface bmp_out_if;
  import bmp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       frame_done;
  logic       error;

  modport source (output valid, output out_byte, output last, output frame_done,
                  output error, input ready);
  modport sink   (input valid, input out_byte, input last, input frame_done,
                  input error, output ready);
endinterface

interface bmp_cfg_if;
  import bmp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/bmp_front.sv
// Front end: configuration registers, frame tracking and job classification.
`timescale 1ns / 1ps

module bmp_front (
  input  logic          clk,
  input  logic          rst_n,
  bmp_cfg_if.sink       cfg_ch,
  bmp_in_if.sink        in_ch,
  output logic          push_valid,
  output bmp_pkg::cmd_t push_data,
  input  logic          push_ready
);
  import bmp_pkg::*;

  logic [WIDTH_W-1:0]  image_width_r;
  logic [HEIGHT_W-1:0] image_height_r;
  logic [WIDTH_W-1:0]  cur_w_r, cur_w_nxt;
  logic [WIDTH_W-1:0]  cur_h_r, cur_h_nxt;
  logic [WIDTH_W-1:0]  col_r, col_nxt;
  logic [WIDTH_W-1:0]  row_r, row_nxt;
  logic                open_r, open_nxt;

  logic                accept;
  logic [WIDTH_W-1:0]  w_eff;
  logic                neg;
  logic [HEIGHT_W-1:0] mag_raw;
  logic [WIDTH_W-1:0]  mag;
  logic [14:0]         bw_sum;
  logic [14:0]         byte_w;
  logic [ARR_W-1:0]    arr;
  logic [HEIGHT_W-1:0] hfield;
  logic [WIDTH_W-1:0]  col_inc;
  logic [WIDTH_W-1:0]  row_inc;
  logic                row_end;
  logic                file_end;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_W'(1);
      image_height_r <= HEIGHT_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_ch.data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_ch.data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions from the registers, saturated to the supported range.
  always_comb begin
    if (image_width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (image_width_r > WIDTH_W'(MAX_DIM)) begin
      w_eff = WIDTH_W'(MAX_DIM);
    end else begin
      w_eff = image_width_r;
    end
    neg     = image_height_r[HEIGHT_W-1];
    mag_raw = neg ? (HEIGHT_W'(0) - image_height_r) : image_height_r;
    if (mag_raw > HEIGHT_W'(MAX_DIM)) begin
      mag = WIDTH_W'(MAX_DIM);
    end else begin
      mag = mag_raw[WIDTH_W-1:0];
    end
    bw_sum = 15'({2'b00, w_eff}) + 15'({1'b0, w_eff, 1'b0}) + 15'd3;
    byte_w = {bw_sum[14:2], 2'b00};
    arr    = ARR_W'(byte_w) * ARR_W'(mag);
    hfield = neg ? (HEIGHT_W'(0) - {1'b0, mag}) : {1'b0, mag};
  end

  assign col_inc  = col_r + WIDTH_W'(1);
  assign row_inc  = row_r + WIDTH_W'(1);
  assign row_end  = (col_inc >= cur_w_r);
  assign file_end = row_end && (row_inc >= cur_h_r);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid && push_ready;

  always_comb begin
    push_data            = '0;
    push_data.hdr_width  = w_eff;
    push_data.hdr_height = hfield;
    push_data.hdr_arr    = arr;
    push_data.hdr_empty  = (mag == '0);
    push_data.px_blue    = in_ch.pixel_word[15:8];
    push_data.px_green   = in_ch.pixel_word[23:16];
    push_data.px_red     = in_ch.pixel_word[31:24];
    push_data.pad        = row_end ? cur_w_r[1:0] : 2'b00;
    push_data.file_end   = file_end;

    cur_w_nxt = cur_w_r;
    cur_h_nxt = cur_h_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    open_nxt  = open_r;

    if (!in_ch.op) begin
      push_data.kind = CMD_HEADER;
    end else if (!open_r) begin
      push_data.kind = CMD_ERROR;
    end else begin
      push_data.kind = CMD_PIXEL;
    end

    if (accept) begin
      if (!in_ch.op) begin
        cur_w_nxt = w_eff;
        cur_h_nxt = mag;
        col_nxt   = '0;
        row_nxt   = '0;
        open_nxt  = (mag != '0);
      end else if (open_r) begin
        col_nxt = col_inc;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_inc;
          if (file_end) begin
            row_nxt  = '0;
            open_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_w_r <= WIDTH_W'(1);
      cur_h_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
      open_r  <= 1'b0;
    end else begin
      cur_w_r <= cur_w_nxt;
      cur_h_r <= cur_h_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule

>>> rtl/core/bmp_cmd_queue.sv
// Two-entry job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module bmp_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  bmp_pkg::cmd_t push_data,
  output logic          push_ready,
  output logic          pop_valid,
  output bmp_pkg::cmd_t pop_data,
  input  logic          pop
);
  import bmp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/core/bmp_back.sv
// Byte sequencer: turns queued jobs into file bytes through an output register.
`timescale 1ns / 1ps

module bmp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  input  bmp_pkg::cmd_t pop_data,
  output logic          pop,
  bmp_out_if.source     out_ch
);
  import bmp_pkg::*;

  bk_state_t  state_r, state_nxt;
  cmd_t       cur_r, cur_nxt;
  logic [5:0] pos_r, pos_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_done_r;
  logic       out_err_r;

  logic       load_ok;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_last;
  logic       emit_done;
  logic       emit_err;

  // The header is thirteen little-endian words after the two magic bytes.
  function automatic logic [7:0] header_byte(input logic [5:0] pos, input cmd_t c);
    logic [5:0]  off;
    logic [31:0] word;
    logic [31:0] arr32;
    off   = pos - 6'd2;
    arr32 = {{(32-ARR_W){1'b0}}, c.hdr_arr};
    case (off[5:2])
      4'd0:    word = HDR_OFFSET + arr32;
      4'd1:    word = HDR_RESERVED;
      4'd2:    word = HDR_OFFSET;
      4'd3:    word = HDR_INFO_SIZE;
      4'd4:    word = {{(32-WIDTH_W){1'b0}}, c.hdr_width};
      4'd5:    word = {{(32-HEIGHT_W){c.hdr_height[HEIGHT_W-1]}}, c.hdr_height};
      4'd6:    word = HDR_PLANES_BPP;
      4'd8:    word = arr32;
      4'd9:    word = HDR_DPM;
      4'd10:   word = HDR_DPM;
      default: word = 32'd0;
    endcase
    if (pos == 6'd0) begin
      return HDR_MAGIC_B;
    end else if (pos == 6'd1) begin
      return HDR_MAGIC_M;
    end
    return word[8*off[1:0] +: 8];
  endfunction

  assign load_ok = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    pos_nxt   = pos_r;
    pop       = 1'b0;
    emit      = 1'b0;
    emit_byte = 8'd0;
    emit_last = 1'b0;
    emit_done = 1'b0;
    emit_err  = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
      end
      BK_HEADER: begin
        emit      = load_ok;
        emit_byte = header_byte(pos_r, cur_r);
        emit_last = (pos_r == HDR_LAST_POS);
        emit_done = emit_last && cur_r.hdr_empty;
      end
      BK_PIXEL: begin
        emit = load_ok;
        case (pos_r)
          6'd0:    emit_byte = cur_r.px_blue;
          6'd1:    emit_byte = cur_r.px_green;
          6'd2:    emit_byte = cur_r.px_red;
          default: emit_byte = 8'd0;
        endcase
        emit_last = (pos_r == 6'd2 + {4'd0, cur_r.pad});
        emit_done = emit_last && cur_r.file_end;
      end
      BK_ERROR: begin
        emit      = load_ok;
        emit_last = 1'b1;
        emit_err  = 1'b1;
      end
      default: begin
      end
    endcase

    if (emit && !emit_last) begin
      pos_nxt = pos_r + 6'd1;
    end

    // Take the next job on the last byte of this one, or at once when idle.
    if ((state_r == BK_IDLE) || (emit && emit_last)) begin
      state_nxt = BK_IDLE;
      if (pop_valid) begin
        pop     = 1'b1;
        cur_nxt = pop_data;
        pos_nxt = 6'd0;
        unique case (pop_data.kind)
          CMD_HEADER: state_nxt = BK_HEADER;
          CMD_PIXEL:  state_nxt = BK_PIXEL;
          CMD_ERROR:  state_nxt = BK_ERROR;
          default:    state_nxt = BK_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      pos_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
      out_done_r <= emit_done;
      out_err_r  <= emit_err;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.frame_done = out_done_r;
  assign out_ch.error      = out_err_r;

endmodule

>>> rtl/core/bmp24_stream_encoder.sv
// Top level of the 24-bit BMP byte-stream encoder.
//
//   channel  | direction | payload                              | transfer when
//   ---------+-----------+--------------------------------------+-------------------
//   cfg_ch   | in        | index (8), data (14)                 | valid && ready
//   in_ch    | in        | op (1), pixel_word (32)              | valid && ready
//   out_ch   | out       | out_byte (8), last, frame_done, error| valid && ready
//
// One byte leaves per unstalled cycle: a start item gives 54 bytes, a pixel 3 bytes plus
// up to 3 padding bytes at a row end, an error answer one byte. An item that finds the
// sequencer idle passes through a job queue slot, the sequencer's job register and the
// output register before its first byte is presented.
// The front end and a two-entry job queue keep accepting items while bytes stall, until the queue is full.
// Reset is synchronous and active low; cfg_ch is always ready.
`timescale 1ns / 1ps

module bmp24_stream_encoder (
  input  logic      clk,
  input  logic      rst_n,
  bmp_cfg_if.sink   cfg_ch,
  bmp_in_if.sink    in_ch,
  bmp_out_if.source out_ch
);
  import bmp_pkg::*;

  logic push_valid;
  cmd_t push_data;
  logic push_ready;
  logic pop_valid;
  cmd_t pop_data;
  logic pop;

  bmp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  bmp_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  bmp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/core/bmp_checker.sv
// Port-level assertions for the BMP stream encoder and their binding.
`timescale 1ns / 1ps

module bmp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_frame_done,
  input logic       out_error
);

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_frame_done) && $stable(out_error))
    else $error("result changed while stalled");

  // An error answer is a single zero byte that closes nothing.
  a_error_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && !out_frame_done && (out_byte == 8'd0))
    else $error("malformed error answer");

  // The end of the file is always the end of an item's answer.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last && !out_error)
    else $error("frame_done without last");

  // Reset empties the output register.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bmp24_stream_encoder bmp_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte       (out_ch.out_byte),
  .out_last       (out_ch.last),
  .out_frame_done (out_ch.frame_done),
  .out_error      (out_ch.error)
);

>>> test/bmp24_stream_checker.sv
// Checker for the BMP stream encoder, with the opcode names the testbench shares with it.
`timescale 1ns / 1ps

package bmp_tb_pkg;
  typedef enum logic {
    OP_START = 1'b0,
    OP_PIXEL = 1'b1
  } bmp_op_t;
endpackage

module bmp24_stream_checker (
  input  logic clk,
  input  logic rst_n,
  bmp_cfg_if   cfg_ch,
  bmp_in_if    in_ch,
  bmp_out_if   out_ch,
  output int   fail_count,
  output int   outstanding
);
  import bmp_pkg::*;
  import bmp_tb_pkg::*;

  localparam int          DIM_LIMIT    = 4096;
  localparam int          HDR_BYTES    = 54;
  localparam logic [15:0] FILE_MAGIC   = 16'h4D42;
  localparam logic [15:0] RESERVED_LO  = 16'h6552;
  localparam logic [15:0] RESERVED_HI  = 16'h656E;
  localparam logic [31:0] PIXEL_OFFSET = 32'd54;
  localparam logic [31:0] INFO_SIZE    = 32'd40;
  localparam logic [15:0] PLANE_COUNT  = 16'd1;
  localparam logic [15:0] BIT_DEPTH    = 16'd24;
  localparam logic [31:0] NO_COMPRESS  = 32'd0;
  localparam logic [31:0] DOTS_PER_M   = 32'd2835;
  localparam logic [31:0] NO_PALETTE   = 32'd0;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       frame_done;
    logic       error;
  } file_byte_t;

  file_byte_t  file_bytes_q[$];
  logic [12:0] reg_width;
  logic [13:0] reg_height;
  logic [12:0] frame_w;
  logic [12:0] frame_h;
  logic [12:0] col_pos;
  logic [12:0] row_pos;
  logic        frame_open;
  int          byte_no;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic queue_byte(input logic [7:0] d, input logic l, input logic f, input logic e);
    file_bytes_q.push_back('{d, l, f, e});
  endtask

  // Header bytes are packed with the first file byte in the lowest bits, so every
  // multi-byte field lands little-endian without further shuffling.
  task automatic predict_header();
    logic [12:0]            w;
    logic                   neg;
    int                     mag;
    logic [31:0]            row_bytes;
    logic [31:0]            arr;
    logic [31:0]            hfield;
    logic [HDR_BYTES*8-1:0] hdr;
    w = reg_width;
    if (w == 0) w = 13'd1;
    if (w > DIM_LIMIT) w = 13'(DIM_LIMIT);
    neg = reg_height[13];
    mag = neg ? 16384 - int'(reg_height) : int'(reg_height);
    if (mag > DIM_LIMIT) mag = DIM_LIMIT;
    row_bytes = (32'(w) * 3 + 3) & ~32'd3;
    arr       = row_bytes * 32'(mag);
    hfield    = neg ? -32'(mag) : 32'(mag);
    hdr = {NO_PALETTE, NO_PALETTE, DOTS_PER_M, DOTS_PER_M, arr, NO_COMPRESS, BIT_DEPTH,
           PLANE_COUNT, hfield, 32'(w), INFO_SIZE, PIXEL_OFFSET, RESERVED_HI, RESERVED_LO,
           PIXEL_OFFSET + arr, FILE_MAGIC};
    for (int i = 0; i < HDR_BYTES; i++)
      queue_byte(hdr[8*i +: 8], i == HDR_BYTES - 1, (i == HDR_BYTES - 1) && (mag == 0), 1'b0);
    frame_w    = w;
    frame_h    = 13'(mag);
    col_pos    = '0;
    row_pos    = '0;
    frame_open = (mag != 0);
  endtask

  task automatic predict_pixel(input logic [31:0] word);
    logic       row_end;
    logic       file_end;
    logic [1:0] pad;
    if (!frame_open) begin
      queue_byte(8'h00, 1'b1, 1'b0, 1'b1);
      return;
    end
    col_pos  = col_pos + 13'd1;
    row_end  = (col_pos >= frame_w);
    pad      = row_end ? frame_w[1:0] : 2'd0;
    file_end = row_end && (int'(row_pos) + 1 >= int'(frame_h));
    queue_byte(word[15:8], 1'b0, 1'b0, 1'b0);
    queue_byte(word[23:16], 1'b0, 1'b0, 1'b0);
    queue_byte(word[31:24], pad == 0, file_end && (pad == 0), 1'b0);
    for (int i = 1; i <= pad; i++)
      queue_byte(8'h00, i == pad, file_end && (i == pad), 1'b0);
    if (row_end) begin
      col_pos = '0;
      row_pos = row_pos + 13'd1;
      if (file_end) begin
        frame_open = 1'b0;
        row_pos    = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    file_byte_t got;
    file_byte_t want;
    if (!rst_n) begin
      reg_width  = 13'd1;
      reg_height = 14'd1;
      frame_w    = 13'd1;
      frame_h    = '0;
      col_pos    = '0;
      row_pos    = '0;
      frame_open = 1'b0;
      byte_no    = 0;
      file_bytes_q.delete();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.out_byte, out_ch.last, out_ch.frame_done, out_ch.error};
        if (file_bytes_q.size() == 0) begin
          report_mismatch($sformatf("byte %0d (%02h) came with nothing expected",
                                    byte_no, got.data));
        end else begin
          want = file_bytes_q.pop_front();
          if (got.data !== want.data)
            report_mismatch($sformatf("byte %0d: out_byte %02h, expected %02h",
                                      byte_no, got.data, want.data));
          if (got.last !== want.last)
            report_mismatch($sformatf("byte %0d: last %b, expected %b",
                                      byte_no, got.last, want.last));
          if (got.frame_done !== want.frame_done)
            report_mismatch($sformatf("byte %0d: frame_done %b, expected %b",
                                      byte_no, got.frame_done, want.frame_done));
          if (got.error !== want.error)
            report_mismatch($sformatf("byte %0d: error %b, expected %b",
                                      byte_no, got.error, want.error));
        end
        byte_no++;
      end
      // New register values are only picked up by the next start.
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        if (cfg_ch.index == REG_IMAGE_WIDTH)
          reg_width = cfg_ch.data[12:0];
        else if (cfg_ch.index == REG_IMAGE_HEIGHT)
          reg_height = cfg_ch.data[13:0];
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        if (in_ch.op == OP_PIXEL)
          predict_pixel(in_ch.pixel_word);
        else
          predict_header();
      end
    end
    outstanding = file_bytes_q.size();
  end

endmodule

>>> test/bmp24_stream_encoder_tb.sv
// Testbench top for the BMP stream encoder: stimulus, back-pressure and the verdict.
`timescale 1ns / 1ps

module bmp24_stream_encoder_tb;
  import bmp_pkg::*;
  import bmp_tb_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP   = 8'hFF;
  localparam int                     RANDOM_ITEMS = 100;

  logic clk;
  logic rst_n;
  bit   src_steady;
  bit   sink_steady;
  int   items_sent;
  int   fail_count;
  int   outstanding;

  bmp_cfg_if cfg_ch ();
  bmp_in_if  in_ch ();
  bmp_out_if out_ch ();

  bmp24_stream_encoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bmp24_stream_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ch      (cfg_ch),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int hold;
    int n;
    hold         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        n = sink_steady ? 0 : idle_cycles();
        if (n == 0) begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(0, 5);
        end else begin
          out_ch.ready <= 1'b0;
          hold = n - 1;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  task automatic send_item(input bmp_op_t op, input logic [31:0] word);
    int gap;
    gap = src_steady ? 0 : idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.pixel_word <= word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  // Drops both request lines and waits until every expected byte has been seen,
  // plus a short margin for the sequencer to go idle.
  task automatic settle();
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int          w_eff;
    int          mag;
    int          npx;
    int          r;
    logic        neg;
    logic [12:0] w_raw;
    logic [13:0] h_raw;

    rst_n            = 1'b0;
    src_steady       = 1'b0;
    sink_steady      = 1'b0;
    items_sent       = 0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_START;
    in_ch.pixel_word = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry is one by one: a pixel before any start is an error.
    send_item(OP_PIXEL, 32'h1234_5678);
    send_item(OP_START, 32'h0);
    send_item(OP_PIXEL, 32'hFFFF_FFFF);
    send_item(OP_PIXEL, 32'h0000_0000);
    settle();

    // Three pixels wide, two rows top-down; then a restart over an open frame.
    write_reg(REG_IMAGE_WIDTH, 14'd3);
    write_reg(REG_IMAGE_HEIGHT, 14'h3FFE);
    settle();
    send_item(OP_START, 32'hFFFF_FFFF);
    send_item(OP_PIXEL, 32'h0000_0000);
    send_item(OP_PIXEL, 32'hFFFF_FFFF);
    send_item(OP_PIXEL, 32'hA5A5_A5A5);
    send_item(OP_PIXEL, 32'h5A5A_5A5A);
    send_item(OP_PIXEL, 32'h0F0F_0F0F);
    send_item(OP_PIXEL, 32'hF0F0_F0F0);
    send_item(OP_START, 32'h0);
    send_item(OP_PIXEL, 32'h8040_2010);
    send_item(OP_START, 32'h0);
    settle();

    // Width zero acts as one; height zero gives an empty file and no frame.
    write_reg(REG_IMAGE_WIDTH, 14'd0);
    write_reg(REG_IMAGE_HEIGHT, 14'd0);
    settle();
    send_item(OP_START, 32'h0);
    send_item(OP_PIXEL, 32'hDEAD_BEEF);
    settle();

    // Saturation of both dimensions; writes to unknown indexes change nothing.
    write_reg(REG_IMAGE_WIDTH, 14'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 14'h2000);
    write_reg(REG_SPARE, 14'h3FFF);
    write_reg(REG_TOP, 14'h0000);
    settle();
    send_item(OP_START, 32'h0);
    settle();
    write_reg(REG_IMAGE_WIDTH, 14'd4096);
    write_reg(REG_IMAGE_HEIGHT, 14'h1FFF);
    settle();
    send_item(OP_START, 32'h0);
    send_item(OP_PIXEL, 32'h0102_0304);
    settle();

    // A width that is a multiple of four needs no padding.
    write_reg(REG_IMAGE_WIDTH, 14'd4);
    write_reg(REG_IMAGE_HEIGHT, 14'd1);
    settle();
    send_item(OP_START, 32'h0);
    repeat (4) send_item(OP_PIXEL, $urandom());
    settle();

    // Random frames until the whole run has sent about the planned number of items.
    while (items_sent < RANDOM_ITEMS) begin
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);

      r = $urandom_range(0, 99);
      if (r < 85) w_raw = 13'($urandom_range(1, 9));
      else if (r < 95) w_raw = 13'($urandom_range(10, 40));
      else w_raw = 13'($urandom_range(4090, 8191));

      r   = $urandom_range(0, 99);
      neg = 1'($urandom_range(0, 1));
      if (r < 80) mag = $urandom_range(1, 4);
      else if (r < 88) mag = 0;
      else mag = $urandom_range(4000, neg ? 8192 : 8191);
      h_raw = neg ? 14'(16384 - mag) : 14'(mag);

      write_reg(REG_IMAGE_WIDTH, {1'($urandom_range(0, 1)), w_raw});
      write_reg(REG_IMAGE_HEIGHT, h_raw);
      if ($urandom_range(0, 9) == 0)
        write_reg(8'($urandom_range(2, 255)), 14'($urandom()));
      settle();

      w_eff = (w_raw == 0) ? 1 : ((w_raw > 4096) ? 4096 : int'(w_raw));
      if (mag > 4096) mag = 4096;
      npx = w_eff * mag;
      // Large frames are only begun; small ones are mostly completed.
      if (npx > 30) npx = $urandom_range(1, 12);
      else if (npx > 0 && $urandom_range(0, 6) == 0) npx = $urandom_range(0, npx - 1);

      if ($urandom_range(0, 9) == 0) send_item(OP_PIXEL, $urandom());
      send_item(OP_START, $urandom());
      repeat (npx) send_item(OP_PIXEL, $urandom());
      if ($urandom_range(0, 9) == 0) send_item(OP_PIXEL, $urandom());
      settle();
    end

    for (int k = 0; k < 100000 && outstanding != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (outstanding != 0)
      $display("%0d expected bytes never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
rtl/core/bmp_pkg.sv
rtl/core/bmp_ifs.sv
rtl/core/bmp_front.sv
rtl/core/bmp_cmd_queue.sv
rtl/core/bmp_back.sv
rtl/core/bmp24_stream_encoder.sv
rtl/core/bmp_checker.sv
test/bmp24_stream_checker.sv
test/bmp24_stream_encoder_tb.sv
